// File: rtl/core/queue_admission_credit_accounting_unit_assert.svh
// assertion macros shared by the queue admission accounting rtl
`ifndef QUEUE_ADMISSION_CREDIT_ACCOUNTING_UNIT_ASSERT_SVH
`define QUEUE_ADMISSION_CREDIT_ACCOUNTING_UNIT_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define QACA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define QACA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/qaca_pkg.sv
`default_nettype none

package qaca_pkg;

    // command codes carried in s_tuser
    typedef enum logic [3:0] {
        CMD_PUSH     = 4'd0,
        CMD_RESERVE  = 4'd1,
        CMD_GROW     = 4'd2,
        CMD_COMMIT   = 4'd3,
        CMD_CANCEL   = 4'd4,
        CMD_COMPLETE = 4'd5,
        CMD_POP      = 4'd6,
        CMD_PAUSE    = 4'd7,
        CMD_CLOSE    = 4'd8
    } cmd_e;

    localparam int CMD_W     = 4;
    localparam int FIELD_MSG = 16;
    localparam int FIELD_BYT = 32;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 168;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MESSAGE_CAPACITY = 1'b0,
        CFG_BYTE_CAPACITY    = 1'b1
    } cfg_idx_e;

    localparam logic [FIELD_MSG-1:0] MSG_CAP_RESET  = 16'd1024;
    localparam logic [FIELD_BYT-1:0] BYTE_CAP_RESET = 32'd16777216;

    typedef struct packed {
        logic paused;
        logic closed;
    } flags_t;

    // one result word at port widths
    typedef struct packed {
        logic                 accepted;
        logic [FIELD_BYT-1:0] granted_bytes;
        logic [FIELD_MSG-1:0] popped_count;
        logic [FIELD_MSG-1:0] queued_msgs;
        logic [FIELD_MSG-1:0] reserved_messages;
        logic [FIELD_MSG-1:0] in_flight_messages;
        logic [FIELD_BYT-1:0] queued_bytes;
        logic [FIELD_BYT-1:0] reserved_byte_total;
        logic                 paused;
        logic                 closed;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/queue_admission_credit_accounting_unit.sv
// Admission accounting for a bounded message queue (counts only, no payload).
// Input channel s_*: one command word per handshake, the command code in
// s_tuser and its operands in s_tdata. Result channel m_*: one result word
// per command with the success flag, granted bytes, popped count and the
// full counter snapshot after the command.
// Configuration channel cfg_*: index 0 message capacity, index 1 byte
// capacity; always ready, write only while no command is in progress.
// A command word is first taken into the input register, then its result is
// written to the result register, which drives m_tvalid. Throughput: one
// command per cycle while m_tready stays high, set by the combinational
// counter update between those registers.
// Reset (aresetn low at a clock edge) clears all counters and both flags,
// loads the capacities with 1024 messages and 16777216 bytes, and empties
// both registers. When the receiver holds m_tready low the result word is
// held, one more command is taken into the input register, and s_tready then
// drops until the result is taken.
`default_nettype none

module queue_admission_credit_accounting_unit #(
    parameter int MSG_COUNT_WIDTH  = 16,
    parameter int BYTE_COUNT_WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [qaca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [qaca_pkg::FIELD_BYT-1:0]      cfg_data,
    // commands
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // size_arg[31:0], preferred_bytes[63:32], content_bytes[95:64],
    // msg_count[111:96], pause_value[112], zero[119:113]
    input  wire logic [qaca_pkg::S_TDATA_W-1:0]      s_tdata,
    // command[3:0]
    input  wire logic [qaca_pkg::CMD_W-1:0]          s_tuser,
    // results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // accepted[0], granted_bytes[32:1], popped_count[48:33],
    // queued_msgs[64:49], reserved_messages[80:65],
    // in_flight_messages[96:81], queued_bytes[128:97],
    // reserved_byte_total[160:129], paused[161], closed[162], zero[167:163]
    output logic [qaca_pkg::M_TDATA_W-1:0]           m_tdata
);

    logic [MSG_COUNT_WIDTH-1:0]  msg_cap;
    logic [BYTE_COUNT_WIDTH-1:0] byte_cap;

    // input register
    logic                                in_valid_reg, in_valid_next;
    logic [qaca_pkg::CMD_W-1:0]          cmd_reg;
    logic [qaca_pkg::FIELD_BYT-1:0]      size_reg, pref_reg, content_reg;
    logic [qaca_pkg::FIELD_MSG-1:0]      count_reg;
    logic                                pv_reg;

    // counters
    logic [MSG_COUNT_WIDTH-1:0]  q_cnt_reg,  r_cnt_reg,  f_cnt_reg;
    logic [MSG_COUNT_WIDTH-1:0]  q_cnt_next, r_cnt_next, f_cnt_next;
    logic [BYTE_COUNT_WIDTH-1:0] qb_cnt_reg, rb_cnt_reg;
    logic [BYTE_COUNT_WIDTH-1:0] qb_cnt_next, rb_cnt_next;
    qaca_pkg::flags_t            flags_reg, flags_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    qaca_pkg::result_t           res_reg, res_next;

    logic out_free, advance, take_in;

    qaca_cfg #(
        .MSG_COUNT_WIDTH  (MSG_COUNT_WIDTH),
        .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg_cap   (msg_cap),
        .byte_cap  (byte_cap)
    );

    qaca_exec #(
        .MSG_COUNT_WIDTH  (MSG_COUNT_WIDTH),
        .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
    ) u_exec (
        .msg_cap         (msg_cap),
        .byte_cap        (byte_cap),
        .command         (cmd_reg),
        .size_arg        (size_reg),
        .preferred_bytes (pref_reg),
        .content_bytes   (content_reg),
        .msg_count       (count_reg),
        .pause_value     (pv_reg),
        .q_cnt           (q_cnt_reg),
        .r_cnt           (r_cnt_reg),
        .f_cnt           (f_cnt_reg),
        .qb_cnt          (qb_cnt_reg),
        .rb_cnt          (rb_cnt_reg),
        .flags           (flags_reg),
        .q_cnt_next      (q_cnt_next),
        .r_cnt_next      (r_cnt_next),
        .f_cnt_next      (f_cnt_next),
        .qb_cnt_next     (qb_cnt_next),
        .rb_cnt_next     (rb_cnt_next),
        .flags_next      (flags_next),
        .result          (res_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign take_in  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            q_cnt_reg     <= '0;
            r_cnt_reg     <= '0;
            f_cnt_reg     <= '0;
            qb_cnt_reg    <= '0;
            rb_cnt_reg    <= '0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // state moves together with the result word
            if (advance) begin
                q_cnt_reg  <= q_cnt_next;
                r_cnt_reg  <= r_cnt_next;
                f_cnt_reg  <= f_cnt_next;
                qb_cnt_reg <= qb_cnt_next;
                rb_cnt_reg <= rb_cnt_next;
                flags_reg  <= flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            cmd_reg     <= s_tuser;
            size_reg    <= s_tdata[31:0];
            pref_reg    <= s_tdata[63:32];
            content_reg <= s_tdata[95:64];
            count_reg   <= s_tdata[111:96];
            pv_reg      <= s_tdata[112];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        5'b0,
        res_reg.closed,
        res_reg.paused,
        res_reg.reserved_byte_total,
        res_reg.queued_bytes,
        res_reg.in_flight_messages,
        res_reg.reserved_messages,
        res_reg.queued_msgs,
        res_reg.popped_count,
        res_reg.granted_bytes,
        res_reg.accepted
    };

`include "queue_admission_credit_accounting_unit_assert.svh"

    `QACA_ASSERT_NEXT(a_in_kept, in_valid_reg && !out_free, in_valid_reg, "command word lost")
    `QACA_ASSERT_NEXT(a_adv_out, advance, out_valid_reg, "advanced command produced no result")
    `QACA_ASSERT_NOW(a_acc_open, out_valid_reg && res_reg.accepted, !flags_reg.closed, "accepted while closed")
    `QACA_ASSERT_NOW(a_grant_rsv, out_valid_reg && (res_reg.granted_bytes != '0), r_cnt_reg != '0, "grant w/o reservation")
    `QACA_ASSERT_NEXT(a_closed_sticky, flags_reg.closed, flags_reg.closed, "closed flag cleared")

endmodule

`default_nettype wire

// File: rtl/core/qaca_cfg.sv
`default_nettype none

module qaca_cfg #(
    parameter int MSG_COUNT_WIDTH  = 16,
    parameter int BYTE_COUNT_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [qaca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [qaca_pkg::FIELD_BYT-1:0]    cfg_data,
    output logic [MSG_COUNT_WIDTH-1:0]             msg_cap,
    output logic [BYTE_COUNT_WIDTH-1:0]            byte_cap
);

    logic [MSG_COUNT_WIDTH-1:0]  msg_cap_reg,  msg_cap_next;
    logic [BYTE_COUNT_WIDTH-1:0] byte_cap_reg, byte_cap_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        msg_cap_next  = msg_cap_reg;
        byte_cap_next = byte_cap_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                qaca_pkg::CFG_MESSAGE_CAPACITY: begin
                    msg_cap_next = MSG_COUNT_WIDTH'(cfg_data[qaca_pkg::FIELD_MSG-1:0]);
                end
                qaca_pkg::CFG_BYTE_CAPACITY: begin
                    byte_cap_next = BYTE_COUNT_WIDTH'(cfg_data);
                end
                default: begin
                    msg_cap_next  = msg_cap_reg;
                    byte_cap_next = byte_cap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_cap_reg  <= MSG_COUNT_WIDTH'(qaca_pkg::MSG_CAP_RESET);
            byte_cap_reg <= BYTE_COUNT_WIDTH'(qaca_pkg::BYTE_CAP_RESET);
        end else begin
            msg_cap_reg  <= msg_cap_next;
            byte_cap_reg <= byte_cap_next;
        end
    end

    assign msg_cap  = msg_cap_reg;
    assign byte_cap = byte_cap_reg;

endmodule

`default_nettype wire

// File: rtl/core/qaca_exec.sv
`default_nettype none

module qaca_exec #(
    parameter int MSG_COUNT_WIDTH  = 16,
    parameter int BYTE_COUNT_WIDTH = 32
) (
    input  wire logic [MSG_COUNT_WIDTH-1:0]          msg_cap,
    input  wire logic [BYTE_COUNT_WIDTH-1:0]         byte_cap,
    input  wire logic [qaca_pkg::CMD_W-1:0]          command,
    input  wire logic [qaca_pkg::FIELD_BYT-1:0]      size_arg,
    input  wire logic [qaca_pkg::FIELD_BYT-1:0]      preferred_bytes,
    input  wire logic [qaca_pkg::FIELD_BYT-1:0]      content_bytes,
    input  wire logic [qaca_pkg::FIELD_MSG-1:0]      msg_count,
    input  wire logic                                pause_value,
    input  wire logic [MSG_COUNT_WIDTH-1:0]          q_cnt,
    input  wire logic [MSG_COUNT_WIDTH-1:0]          r_cnt,
    input  wire logic [MSG_COUNT_WIDTH-1:0]          f_cnt,
    input  wire logic [BYTE_COUNT_WIDTH-1:0]         qb_cnt,
    input  wire logic [BYTE_COUNT_WIDTH-1:0]         rb_cnt,
    input  wire qaca_pkg::flags_t                    flags,
    output logic [MSG_COUNT_WIDTH-1:0]               q_cnt_next,
    output logic [MSG_COUNT_WIDTH-1:0]               r_cnt_next,
    output logic [MSG_COUNT_WIDTH-1:0]               f_cnt_next,
    output logic [BYTE_COUNT_WIDTH-1:0]              qb_cnt_next,
    output logic [BYTE_COUNT_WIDTH-1:0]              rb_cnt_next,
    output qaca_pkg::flags_t                         flags_next,
    output qaca_pkg::result_t                        result
);

    localparam int TOT_W = MSG_COUNT_WIDTH + 2;
    localparam logic [MSG_COUNT_WIDTH-1:0] MSG_ONE = MSG_COUNT_WIDTH'(1);

    logic [BYTE_COUNT_WIDTH-1:0] size_w, pref_w, content_w, adm_bytes;
    logic [MSG_COUNT_WIDTH-1:0]  count_w, popped;
    logic [TOT_W-1:0]            total;
    logic [BYTE_COUNT_WIDTH-1:0] cap_less_bytes, room;
    logic                        admit, room_ok, grow_ok, rsv_hit, done_ok;
    logic [BYTE_COUNT_WIDTH-1:0] granted;
    logic                        accepted;

    assign size_w    = BYTE_COUNT_WIDTH'(size_arg);
    assign pref_w    = BYTE_COUNT_WIDTH'(preferred_bytes);
    assign content_w = BYTE_COUNT_WIDTH'(content_bytes);
    assign count_w   = MSG_COUNT_WIDTH'(msg_count);

    // push checks the message size, reserve the reservation size
    assign adm_bytes = (command == qaca_pkg::CMD_PUSH) ? content_w : size_w;

    // later terms may wrap only when an earlier term has already failed
    assign total = TOT_W'(q_cnt) + TOT_W'(r_cnt) + TOT_W'(f_cnt);
    assign cap_less_bytes = byte_cap - adm_bytes;
    assign admit = !flags.closed && !flags.paused
                && (total < TOT_W'(msg_cap))
                && (adm_bytes <= byte_cap)
                && (qb_cnt <= cap_less_bytes)
                && (rb_cnt <= cap_less_bytes - qb_cnt);

    assign room_ok = (qb_cnt <= byte_cap) && (rb_cnt <= byte_cap - qb_cnt);
    assign room    = byte_cap - qb_cnt - rb_cnt;
    assign grow_ok = (size_w != '0) && (pref_w >= size_w) && !flags.closed
                  && (r_cnt != '0) && room_ok && (room >= size_w);

    assign rsv_hit = (r_cnt != '0) && (rb_cnt >= size_w);
    assign done_ok = (count_w <= f_cnt) && (size_w <= qb_cnt);
    assign popped  = (q_cnt < count_w) ? q_cnt : count_w;

    always_comb begin
        q_cnt_next  = q_cnt;
        r_cnt_next  = r_cnt;
        f_cnt_next  = f_cnt;
        qb_cnt_next = qb_cnt;
        rb_cnt_next = rb_cnt;
        flags_next  = flags;
        accepted    = 1'b0;
        granted     = '0;
        unique case (command)
            qaca_pkg::CMD_PUSH: begin
                if (admit) begin
                    q_cnt_next  = q_cnt + MSG_ONE;
                    qb_cnt_next = qb_cnt + content_w;
                    accepted    = 1'b1;
                end
            end
            qaca_pkg::CMD_RESERVE: begin
                if (admit) begin
                    r_cnt_next  = r_cnt + MSG_ONE;
                    rb_cnt_next = rb_cnt + size_w;
                    accepted    = 1'b1;
                end
            end
            qaca_pkg::CMD_GROW: begin
                if (grow_ok) begin
                    granted     = (pref_w < room) ? pref_w : room;
                    rb_cnt_next = rb_cnt + ((pref_w < room) ? pref_w : room);
                end
            end
            qaca_pkg::CMD_COMMIT: begin
                if (rsv_hit) begin
                    r_cnt_next  = r_cnt - MSG_ONE;
                    rb_cnt_next = rb_cnt - size_w;
                    // refused commit still releases the reservation
                    if (!flags.closed && (content_w <= size_w)) begin
                        q_cnt_next  = q_cnt + MSG_ONE;
                        qb_cnt_next = qb_cnt + content_w;
                        accepted    = 1'b1;
                    end
                end
            end
            qaca_pkg::CMD_CANCEL: begin
                if (rsv_hit) begin
                    r_cnt_next  = r_cnt - MSG_ONE;
                    rb_cnt_next = rb_cnt - size_w;
                end
            end
            qaca_pkg::CMD_COMPLETE: begin
                if (done_ok) begin
                    f_cnt_next  = f_cnt - count_w;
                    qb_cnt_next = qb_cnt - size_w;
                end
            end
            qaca_pkg::CMD_POP: begin
                q_cnt_next = q_cnt - popped;
                f_cnt_next = f_cnt + popped;
            end
            qaca_pkg::CMD_PAUSE: begin
                flags_next.paused = pause_value;
            end
            qaca_pkg::CMD_CLOSE: begin
                flags_next.closed = 1'b1;
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.accepted            = accepted;
        result.granted_bytes       = qaca_pkg::FIELD_BYT'(granted);
        result.popped_count        = (command == qaca_pkg::CMD_POP)
                                   ? qaca_pkg::FIELD_MSG'(popped) : '0;
        result.queued_msgs         = qaca_pkg::FIELD_MSG'(q_cnt_next);
        result.reserved_messages   = qaca_pkg::FIELD_MSG'(r_cnt_next);
        result.in_flight_messages  = qaca_pkg::FIELD_MSG'(f_cnt_next);
        result.queued_bytes        = qaca_pkg::FIELD_BYT'(qb_cnt_next);
        result.reserved_byte_total = qaca_pkg::FIELD_BYT'(rb_cnt_next);
        result.paused              = flags_next.paused;
        result.closed              = flags_next.closed;
    end

endmodule

`default_nettype wire
